FILE: design/assert_macros.svh
// assertion helpers used by the controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check on every rising edge, switched off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// check on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: design/mrc_pkg.sv
`timescale 1ns / 1ps

package mrc_pkg;

  // fixed field widths
  localparam int KEY_W       = 32;
  localparam int RADIX_W     = 8;
  localparam int COUNT_W     = 3;
  localparam int OUT_DIGIT_W = 8;
  localparam int RADIX_REGS  = 4;
  localparam int OUT_DIGITS  = 4;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int REG_IDX_W   = 3;

  // command codes
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_KEY   = 2'd2,
    CMD_LOAD  = 2'd3
  } command_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_WRAP  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_DIGIT_COUNT = 3'd0,
    REG_RADIX_0     = 3'd1,
    REG_RADIX_1     = 3'd2,
    REG_RADIX_2     = 3'd3,
    REG_RADIX_3     = 3'd4
  } reg_idx_t;

  typedef logic [RADIX_REGS-1:0][RADIX_W-1:0] radix_arr_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic total_step;
    logic clear_digits;
    logic idx_zero;
    logic idx_top;
    logic idx_inc;
    logic idx_dec;
    logic step_digit;
    logic div_start;
    logic div_take;
    logic key_step;
    logic set_wrap;
    logic set_range;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic idx_is_zero;
    logic idx_is_last;
    logic step_carry;
    logic div_done;
  } sts_t;

endpackage

FILE: design/mrc_regs.sv
`timescale 1ns / 1ps

module mrc_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mrc_pkg::ADDR_W-1:0]     paddr,
  input  logic [mrc_pkg::DATA_W-1:0]     pwdata,
  output logic [mrc_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  output logic [mrc_pkg::COUNT_W-1:0]    digit_count,
  output mrc_pkg::radix_arr_t            radix
);

  mrc_pkg::reg_idx_t reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = mrc_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= mrc_pkg::COUNT_W'(1);
      for (int i = 0; i < mrc_pkg::RADIX_REGS; i++) begin
        radix[i] <= mrc_pkg::RADIX_W'(1);
      end
    end else if (wr_en) begin
      unique case (reg_idx)
        mrc_pkg::REG_DIGIT_COUNT: digit_count <= pwdata[mrc_pkg::COUNT_W-1:0];
        mrc_pkg::REG_RADIX_0:     radix[0] <= pwdata[mrc_pkg::RADIX_W-1:0];
        mrc_pkg::REG_RADIX_1:     radix[1] <= pwdata[mrc_pkg::RADIX_W-1:0];
        mrc_pkg::REG_RADIX_2:     radix[2] <= pwdata[mrc_pkg::RADIX_W-1:0];
        mrc_pkg::REG_RADIX_3:     radix[3] <= pwdata[mrc_pkg::RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      mrc_pkg::REG_DIGIT_COUNT: prdata = mrc_pkg::DATA_W'(digit_count);
      mrc_pkg::REG_RADIX_0:     prdata = mrc_pkg::DATA_W'(radix[0]);
      mrc_pkg::REG_RADIX_1:     prdata = mrc_pkg::DATA_W'(radix[1]);
      mrc_pkg::REG_RADIX_2:     prdata = mrc_pkg::DATA_W'(radix[2]);
      mrc_pkg::REG_RADIX_3:     prdata = mrc_pkg::DATA_W'(radix[3]);
      default:                  prdata = '0;
    endcase
  end

endmodule

FILE: design/mrc_div.sv
`timescale 1ns / 1ps

module mrc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mrc_pkg::KEY_W-1:0]    dividend,
  input  logic [mrc_pkg::RADIX_W-1:0]  divisor,
  output logic                         done,
  output logic [mrc_pkg::KEY_W-1:0]    quotient,
  output logic [mrc_pkg::RADIX_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(mrc_pkg::KEY_W);

  logic                         run;
  logic [CNT_W-1:0]             cnt;
  logic [mrc_pkg::RADIX_W:0]    trial;
  logic [mrc_pkg::RADIX_W:0]    diff;
  logic                         ge;

  // one quotient bit per cycle, restoring
  assign trial = {remainder, quotient[mrc_pkg::KEY_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(mrc_pkg::KEY_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (run) begin
      quotient  <= {quotient[mrc_pkg::KEY_W-2:0], ge};
      remainder <= ge ? diff[mrc_pkg::RADIX_W-1:0] : trial[mrc_pkg::RADIX_W-1:0];
    end
  end

endmodule

FILE: design/mrc_dp.sv
`timescale 1ns / 1ps

module mrc_dp #(
  parameter int MAX_DIGITS = 4,
  parameter int DIGIT_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mrc_pkg::ctl_t                    ctl,
  output mrc_pkg::sts_t                    sts,
  input  logic [mrc_pkg::COUNT_W-1:0]      digit_count,
  input  mrc_pkg::radix_arr_t              radix,
  input  logic [mrc_pkg::KEY_W-1:0]        key_in,
  output mrc_pkg::status_t                 status,
  output logic [mrc_pkg::KEY_W-1:0]        key_out,
  output logic [mrc_pkg::KEY_W-1:0]        total_count,
  output logic [mrc_pkg::OUT_DIGIT_W-1:0]  digit_out [mrc_pkg::OUT_DIGITS]
);

  localparam int IDXW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int SW     = (DIGIT_BITS + 1 > mrc_pkg::RADIX_W) ? DIGIT_BITS + 1
                                                              : mrc_pkg::RADIX_W;
  localparam int PROD_W = mrc_pkg::KEY_W + mrc_pkg::RADIX_W;

  logic [DIGIT_BITS-1:0]        digits [MAX_DIGITS];
  logic [mrc_pkg::RADIX_W-1:0]  rad_eff [MAX_DIGITS];
  logic [IDXW-1:0]              idx;
  logic [IDXW-1:0]              n_last;
  logic [mrc_pkg::KEY_W-1:0]    key_in_q;
  logic [mrc_pkg::KEY_W-1:0]    work;
  logic [mrc_pkg::RADIX_W-1:0]  rad_cur;
  logic [DIGIT_BITS-1:0]        dig_cur;
  logic [SW-1:0]                d_inc;
  logic [mrc_pkg::KEY_W-1:0]    mul_a;
  logic [PROD_W-1:0]            prod;
  logic [mrc_pkg::KEY_W-1:0]    total_next;
  logic [mrc_pkg::KEY_W-1:0]    key_next;
  logic [IDXW-1:0]              n_last_next;
  logic                         div_done;
  logic [mrc_pkg::KEY_W-1:0]    div_quo;
  logic [mrc_pkg::RADIX_W-1:0]  div_rem;

  // effective radix per digit: zero reads as one, no register means one
  for (genvar j = 0; j < MAX_DIGITS; j++) begin : g_rad
    if (j < mrc_pkg::RADIX_REGS) begin : g_reg
      assign rad_eff[j] = (radix[j] == '0) ? mrc_pkg::RADIX_W'(1) : radix[j];
    end else begin : g_one
      assign rad_eff[j] = mrc_pkg::RADIX_W'(1);
    end
  end

  assign rad_cur = rad_eff[idx];
  assign dig_cur = digits[idx];

  // last digit in use, count clamped to one..MAX_DIGITS
  always_comb begin
    if (digit_count == '0) begin
      n_last_next = '0;
    end else if (32'(digit_count) >= 32'(MAX_DIGITS)) begin
      n_last_next = IDXW'(MAX_DIGITS - 1);
    end else begin
      n_last_next = IDXW'(digit_count - mrc_pkg::COUNT_W'(1));
    end
  end

  // shared 32x8 multiplier for the product and the key
  assign mul_a      = ctl.total_step ? total_count : key_out;
  assign prod       = PROD_W'(mul_a) * PROD_W'(rad_cur);
  assign total_next = (prod[PROD_W-1:mrc_pkg::KEY_W] != '0) ? '1
                                                             : prod[mrc_pkg::KEY_W-1:0];
  assign key_next   = ((idx == '0) ? '0 : prod[mrc_pkg::KEY_W-1:0])
                      + mrc_pkg::KEY_W'(dig_cur);

  // step increment and carry test
  assign d_inc = SW'(dig_cur) + SW'(1);

  assign sts.idx_is_zero = (idx == '0);
  assign sts.idx_is_last = (idx == n_last);
  assign sts.step_carry  = d_inc >= SW'(rad_cur);
  assign sts.div_done    = div_done;

  mrc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (ctl.div_start),
    .dividend  (work),
    .divisor   (rad_cur),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // digit index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (ctl.capture || ctl.idx_zero) begin
      idx <= '0;
    end else if (ctl.idx_top) begin
      idx <= n_last;
    end else if (ctl.idx_inc) begin
      idx <= idx + IDXW'(1);
    end else if (ctl.idx_dec) begin
      idx <= idx - IDXW'(1);
    end
  end

  // digit store
  always_ff @(posedge clk) begin
    if (rst || ctl.clear_digits) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digits[i] <= '0;
      end
    end else if (ctl.step_digit) begin
      digits[idx] <= sts.step_carry ? '0 : DIGIT_BITS'(d_inc);
    end else if (ctl.div_take) begin
      digits[idx] <= DIGIT_BITS'(div_rem);
    end
  end

  // per-command working registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      key_in_q    <= key_in;
      work        <= key_in;
      n_last      <= n_last_next;
      total_count <= mrc_pkg::KEY_W'(1);
    end else begin
      if (ctl.total_step) begin
        total_count <= total_next;
      end
      if (ctl.div_take) begin
        work <= div_quo;
      end
    end
    if (ctl.key_step) begin
      key_out <= key_next;
    end
  end

  // result status
  always_ff @(posedge clk) begin
    if (rst || ctl.capture) begin
      status <= mrc_pkg::ST_OK;
    end else if (ctl.set_wrap) begin
      status <= mrc_pkg::ST_WRAP;
    end else if (ctl.set_range && (key_in_q >= total_count)) begin
      status <= mrc_pkg::ST_RANGE;
    end
  end

  // digits on the result ports, unused digits read zero
  for (genvar i = 0; i < mrc_pkg::OUT_DIGITS; i++) begin : g_out
    if (i < MAX_DIGITS) begin : g_used
      assign digit_out[i] = (IDXW'(i) <= n_last) ? mrc_pkg::OUT_DIGIT_W'(digits[i]) : '0;
    end else begin : g_none
      assign digit_out[i] = '0;
    end
  end

endmodule

FILE: design/mrc_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mrc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     command,
  output logic           busy,
  output logic           done,
  output mrc_pkg::ctl_t  ctl,
  input  mrc_pkg::sts_t  sts
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_TOTAL  = 7'b0000010,
    S_STEP   = 7'b0000100,
    S_DIVGO  = 7'b0001000,
    S_DIVRUN = 7'b0010000,
    S_KEY    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t             state, state_next;
  mrc_pkg::command_t  cmd_q;

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  // state register and latched command
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd_q <= mrc_pkg::CMD_CLEAR;
    end else begin
      state <= state_next;
      if (start && !busy) begin
        cmd_q <= mrc_pkg::command_t'(command);
      end
    end
  end

  // sequencing
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_next  = S_TOTAL;
        end
      end
      S_TOTAL: begin
        ctl.total_step = 1'b1;
        if (sts.idx_is_last) begin
          unique case (cmd_q)
            mrc_pkg::CMD_CLEAR: begin
              ctl.clear_digits = 1'b1;
              ctl.idx_zero     = 1'b1;
              state_next       = S_KEY;
            end
            mrc_pkg::CMD_STEP: begin
              ctl.idx_top = 1'b1;
              state_next  = S_STEP;
            end
            mrc_pkg::CMD_KEY: begin
              ctl.idx_zero = 1'b1;
              state_next   = S_KEY;
            end
            mrc_pkg::CMD_LOAD: begin
              ctl.idx_top = 1'b1;
              state_next  = S_DIVGO;
            end
            default: ;
          endcase
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      S_STEP: begin
        ctl.step_digit = 1'b1;
        if (!sts.step_carry) begin
          ctl.idx_zero = 1'b1;
          state_next   = S_KEY;
        end else if (sts.idx_is_zero) begin
          ctl.set_wrap = 1'b1;
          ctl.idx_zero = 1'b1;
          state_next   = S_KEY;
        end else begin
          ctl.idx_dec = 1'b1;
        end
      end
      S_DIVGO: begin
        ctl.div_start = 1'b1;
        ctl.set_range = 1'b1;
        state_next    = S_DIVRUN;
      end
      S_DIVRUN: begin
        if (sts.div_done) begin
          ctl.div_take = 1'b1;
          if (sts.idx_is_zero) begin
            ctl.idx_zero = 1'b1;
            state_next   = S_KEY;
          end else begin
            ctl.idx_dec = 1'b1;
            state_next  = S_DIVGO;
          end
        end
      end
      S_KEY: begin
        ctl.key_step = 1'b1;
        if (sts.idx_is_last) begin
          state_next = S_DONE;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // checks
  `ASSERT_CLK(a_done_then_idle, clk, rst, done |=> !busy)
  `ASSERT_CLK(a_accept_then_busy, clk, rst, (start && !busy) |=> (busy && !done))
  `ASSERT_CLK(a_wrap_only_at_top, clk, rst, ctl.set_wrap |-> (sts.idx_is_zero && sts.step_carry))
  `ASSERT_ALWAYS(a_no_done_in_reset, clk, rst |=> !done)

endmodule

FILE: design/mixed_radix_cursor.sv
`timescale 1ns / 1ps

// Mixed-radix odometer with up to MAX_DIGITS digits (digit 0 most
// significant), radices set over the register port. A command is taken when
// start is high and busy is low; busy stays high until its single result
// beat, which is on the result ports for exactly one cycle with done high.
// There is no back-pressure: the receiver must take the beat in that cycle.
// Every command first builds the product of radices; a clear then zeroes
// the digits, a step adds one at the last digit with the carry running toward
// digit 0, and a key load divides the key by each radix in the bit-serial
// divider, last digit first. Every command ends by building the key report.
// The product of radices and the key are each built one digit per cycle
// through a single shared 32x8 multiplier.
module mixed_radix_cursor #(
  parameter int MAX_DIGITS = 4,
  parameter int DIGIT_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mrc_pkg::ADDR_W-1:0]       paddr,
  input  logic [mrc_pkg::DATA_W-1:0]       pwdata,
  output logic [mrc_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       command,
  input  logic [mrc_pkg::KEY_W-1:0]        key_in,
  output logic                             done,
  output logic [1:0]                       status,
  output logic [mrc_pkg::KEY_W-1:0]        key_out,
  output logic [mrc_pkg::KEY_W-1:0]        total_count,
  output logic [mrc_pkg::OUT_DIGIT_W-1:0]  digit_0,
  output logic [mrc_pkg::OUT_DIGIT_W-1:0]  digit_1,
  output logic [mrc_pkg::OUT_DIGIT_W-1:0]  digit_2,
  output logic [mrc_pkg::OUT_DIGIT_W-1:0]  digit_3
);

  logic [mrc_pkg::COUNT_W-1:0]      digit_count;
  mrc_pkg::radix_arr_t              radix;
  mrc_pkg::ctl_t                    ctl;
  mrc_pkg::sts_t                    sts;
  mrc_pkg::status_t                 status_q;
  logic [mrc_pkg::OUT_DIGIT_W-1:0]  digit_out [mrc_pkg::OUT_DIGITS];

  // register file
  mrc_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .digit_count (digit_count),
    .radix       (radix)
  );

  // sequencer
  mrc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .busy    (busy),
    .done    (done),
    .ctl     (ctl),
    .sts     (sts)
  );

  // digit store and arithmetic
  mrc_dp #(
    .MAX_DIGITS (MAX_DIGITS),
    .DIGIT_BITS (DIGIT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .digit_count (digit_count),
    .radix       (radix),
    .key_in      (key_in),
    .status      (status_q),
    .key_out     (key_out),
    .total_count (total_count),
    .digit_out   (digit_out)
  );

  assign status  = status_q;
  assign digit_0 = digit_out[0];
  assign digit_1 = digit_out[1];
  assign digit_2 = digit_out[2];
  assign digit_3 = digit_out[3];

endmodule
